// File: rtl/qedp_pkg.sv
// Shared types, constants and the quadrature step table for the encoder core.
// No dependencies; every other file but qedp_bench_pkg imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qedp_pkg;

    // Register map: one bit of address selects the register (byte addresses 0 and 4)
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_REVERSE   = 1'b0;
    localparam logic REG_SHORT_MS  = 1'b1;

    localparam logic [15:0] SHORT_MS_RESET = 16'd250;

    // Accelerator: decay of 65405/65536 per sample, |delta|/8 added in Q8.16
    localparam logic [15:0] DECAY_NUM  = 16'd65405;
    localparam int unsigned ACC_W      = 24;
    localparam int unsigned STEP_SHIFT = 13;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Pin and position reset values
    localparam logic [1:0] PINS_IDLE    = 2'b11;
    localparam logic [7:0] POS_RESET    = 8'd2;
    localparam logic [1:0] DETENT_PHASE = 2'b10;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        reverse_direction;
        logic [15:0] short_press_ms;
    } cfg_t;

    // Button timing results for one tick
    typedef struct packed {
        logic        pressed;
        logic [15:0] press_duration_ms;
        logic        short_release;
        logic        activity;
    } btn_status_t;

    // One result beat
    typedef struct packed {
        logic signed [5:0] detent_steps;
        logic [ACC_W-1:0]  accel_level;
        btn_status_t       btn;
    } tick_result_t;

    // Quadrature step from {new pins, old pins}: +1, -1 or 0
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/qedp_cfg.sv
// APB-style register file: direction reversal and short press limit.
// Depends on qedp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qedp_cfg
    import qedp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic        reverse_reg;
    logic        reverse_next;
    logic [15:0] short_ms_reg;
    logic [15:0] short_ms_next;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write decode
    always_comb
    begin
        reverse_next  = reverse_reg;
        short_ms_next = short_ms_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_REVERSE:  reverse_next  = pwdata[0];
                REG_SHORT_MS: short_ms_next = pwdata[15:0];
                default:      reverse_next  = reverse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg  <= 1'b0;
            short_ms_reg <= SHORT_MS_RESET;
        end
        else
        begin
            reverse_reg  <= reverse_next;
            short_ms_reg <= short_ms_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_REVERSE:  prdata = {31'd0, reverse_reg};
            REG_SHORT_MS: prdata = {16'd0, short_ms_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.reverse_direction = reverse_reg;
    assign cfg.short_press_ms    = short_ms_reg;

endmodule

`default_nettype wire

// File: rtl/qedp_encoder.sv
// Quadrature decode, detent snapping, step consumption and acceleration accumulator.
// Depends on qedp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qedp_encoder
    import qedp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sample_en,
    input  wire logic       tick_en,
    input  wire logic [1:0] pins,
    input  wire logic       reverse_direction,
    output logic signed [5:0] steps,
    output logic [ACC_W-1:0]  accel
);

    logic [1:0]       prev_pins_reg;
    logic [1:0]       prev_pins_next;
    logic [7:0]       position_reg;
    logic [7:0]       position_next;
    logic [ACC_W-1:0] accel_reg;
    logic [ACC_W-1:0] accel_next;

    logic signed [1:0] d;
    logic [7:0]        pos_sample;
    logic [7:0]        diff;
    logic [7:0]        mag;
    logic [39:0]       prod;
    logic [ACC_W:0]    acc_sum;

    // Decode one pin sample
    always_comb
    begin
        d = quad_step({pins, prev_pins_reg});
        if (reverse_direction)
        begin
            d = -d;
        end
        if (pins == PINS_IDLE)
        begin
            pos_sample = {position_reg[7:2], DETENT_PHASE};
        end
        else
        begin
            pos_sample = position_reg + {{6{d[1]}}, d};
        end
        diff = pos_sample - position_reg;
        mag  = diff[7] ? (8'd0 - diff) : diff;
    end

    // Leaky accumulator: decay, add |delta| in Q8.16 / 8, saturate
    assign prod    = {16'd0, accel_reg} * {24'd0, DECAY_NUM};
    assign acc_sum = {1'b0, prod[39:16]} + {4'd0, mag, {STEP_SHIFT{1'b0}}};

    always_comb
    begin
        prev_pins_next = prev_pins_reg;
        position_next  = position_reg;
        accel_next     = accel_reg;
        if (sample_en)
        begin
            prev_pins_next = pins;
            position_next  = pos_sample;
            accel_next     = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        end
        else if (tick_en)
        begin
            // Whole detents leave; the phase within the detent stays
            position_next = {6'd0, position_reg[1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= PINS_IDLE;
            position_reg  <= POS_RESET;
            accel_reg     <= '0;
        end
        else
        begin
            prev_pins_reg <= prev_pins_next;
            position_reg  <= position_next;
            accel_reg     <= accel_next;
        end
    end

    assign steps = position_reg[7:2];
    assign accel = accel_reg;

endmodule

`default_nettype wire

// File: rtl/qedp_button.sv
// Button latch and press timing: press start, press length, short-release flag.
// Depends on qedp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qedp_button
    import qedp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_en,
    input  wire logic        tick_en,
    input  wire logic        button_level,
    input  wire logic [31:0] now,
    input  wire logic        steps_zero,
    input  wire logic [15:0] short_press_ms,
    output btn_status_t      status
);

    logic        down_reg;
    logic        down_next;
    logic        prev_down_reg;
    logic        prev_down_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;

    logic        just_pressed;
    logic        released;
    logic [31:0] start_eff;
    logic [31:0] elapsed;
    logic [15:0] length_now;

    // Press timing seen at a tick
    always_comb
    begin
        just_pressed = down_reg & ~prev_down_reg;
        released     = ~down_reg & prev_down_reg;
        start_eff    = just_pressed ? now : start_reg;
        elapsed      = now - start_eff;
        length_now   = down_reg ? elapsed[15:0] : length_reg;
    end

    always_comb
    begin
        down_next      = down_reg;
        prev_down_next = prev_down_reg;
        start_next     = start_reg;
        length_next    = length_reg;
        if (sample_en)
        begin
            down_next = ~button_level;
        end
        else if (tick_en)
        begin
            prev_down_next = down_reg;
            start_next     = start_eff;
            length_next    = released ? 16'd0 : length_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg      <= 1'b0;
            prev_down_reg <= 1'b0;
            start_reg     <= '0;
            length_reg    <= '0;
        end
        else
        begin
            down_reg      <= down_next;
            prev_down_reg <= prev_down_next;
            start_reg     <= start_next;
            length_reg    <= length_next;
        end
    end

    assign status.pressed           = down_reg;
    assign status.press_duration_ms = length_now;
    assign status.short_release     = released & steps_zero & (length_now <= short_press_ms);
    assign status.activity          = ~steps_zero | down_reg | prev_down_reg;

endmodule

`default_nettype wire

// File: rtl/quadrature_encoder_detent_press_core.sv
// Rotary encoder core, top level: input register, encoder and button state, result register.
// Depends on qedp_pkg, qedp_cfg, qedp_encoder, qedp_button.
`timescale 1ns / 1ps
`default_nettype none

// Quadrature encoder with detent snapping, acceleration estimate and button timing.
// Each input beat is a pin sample (kind 0) or a tick (kind 1); a tick yields one
// result beat, a sample none. Beats are taken one per clock while in_stall is low; a beat
// is captured in the input register and applied to the state from there, and a tick's
// result goes to the result register that drives the outputs. That register holds a tick
// result while out_stall is high; samples keep flowing meanwhile, and only a further tick
// waits for the register to drain, holding off the beats behind it. The longest path is
// the 24x16 constant multiply of the acceleration decay feeding the saturating add.
module quadrature_encoder_detent_press_core
    import qedp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              kind,
    input  wire logic [1:0]        pins,
    input  wire logic              button_level,
    input  wire logic [31:0]       time_ms,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [5:0]      detent_steps,
    output logic [23:0]            accel_level,
    output logic                   pressed,
    output logic [15:0]            press_duration_ms,
    output logic                   short_release,
    output logic                   activity,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t         cfg;
    btn_status_t  btn;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic         kind_reg;
    logic [1:0]   pins_reg;
    logic         button_reg;
    logic [31:0]  time_reg;

    logic         out_valid_reg;
    logic         out_valid_next;
    tick_result_t result_reg;

    logic         go;
    logic         sample_en;
    logic         tick_en;
    logic         in_take;
    logic signed [5:0] steps;
    logic [ACC_W-1:0]  accel;

    qedp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline control: a sample always proceeds, a tick needs room in the result register
    assign go        = in_valid_reg & (~kind_reg | ~out_valid_reg | ~out_stall);
    assign sample_en = go & ~kind_reg;
    assign tick_en   = go & kind_reg;
    assign in_stall  = in_valid_reg & ~go;
    assign in_take   = in_valid & ~in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (tick_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind;
            pins_reg   <= pins;
            button_reg <= button_level;
            time_reg   <= time_ms;
        end
    end

    qedp_encoder u_encoder (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_en         (sample_en),
        .tick_en           (tick_en),
        .pins              (pins_reg),
        .reverse_direction (cfg.reverse_direction),
        .steps             (steps),
        .accel             (accel)
    );

    qedp_button u_button (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_en      (sample_en),
        .tick_en        (tick_en),
        .button_level   (button_reg),
        .now            (time_reg),
        .steps_zero     (steps == 6'sd0),
        .short_press_ms (cfg.short_press_ms),
        .status         (btn)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (tick_en)
        begin
            result_reg.detent_steps <= steps;
            result_reg.accel_level  <= accel;
            result_reg.btn          <= btn;
        end
    end

    assign out_valid         = out_valid_reg;
    assign detent_steps      = result_reg.detent_steps;
    assign accel_level       = result_reg.accel_level;
    assign pressed           = result_reg.btn.pressed;
    assign press_duration_ms = result_reg.btn.press_duration_ms;
    assign short_release     = result_reg.btn.short_release;
    assign activity          = result_reg.btn.activity;

endmodule

`default_nettype wire

// File: rtl/qedp_checker.sv
// Port-level checks for the encoder core, bound onto the top level.
// Depends on qedp_pkg and quadrature_encoder_detent_press_core.
`timescale 1ns / 1ps
`default_nettype none

module qedp_checker
    import qedp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic signed [5:0] detent_steps,
    input wire logic              pressed,
    input wire logic              short_release,
    input wire logic              activity
);

    // A result beat that is held back stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Input is only held off when a result beat is blocked downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result path free");

    // Nonzero detent steps always count as activity
    a_steps_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && detent_steps != 6'sd0 |-> activity)
        else $error("steps reported without activity");

    // A short release means the button is up and no detents moved
    a_short_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_release |-> !pressed && detent_steps == 6'sd0)
        else $error("short release with button down or steps");

endmodule

bind quadrature_encoder_detent_press_core qedp_checker u_qedp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .detent_steps  (detent_steps),
    .pressed       (pressed),
    .short_release (short_release),
    .activity      (activity)
);

`default_nettype wire

// File: bench/qedp_bench_pkg.sv
// Item kind codes shared by the encoder core bench files.
// No dependencies; imported by the tick checker and the bench top.
`timescale 1ns / 1ps

package qedp_bench_pkg;

    // Input beat kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

endpackage

// File: bench/qedp_tick_checker.sv
// Tick result checker: mirrors the encoder, button and config state from the observed
// beats, predicts each tick result and compares it field by field with the core output.
// Depends on qedp_pkg and qedp_bench_pkg.
`timescale 1ns / 1ps

module qedp_tick_checker
    import qedp_pkg::*;
    import qedp_bench_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              kind,
    input  logic [1:0]        pins,
    input  logic              button_level,
    input  logic [31:0]       time_ms,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic signed [5:0] detent_steps,
    input  logic [23:0]       accel_level,
    input  logic              pressed,
    input  logic [15:0]       press_duration_ms,
    input  logic              short_release,
    input  logic              activity,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                pending
);

    // Accelerator arithmetic: decay 65405/65536, each position step adds 1/8 in Q8.16
    localparam logic [39:0] DECAY     = 40'd65405;
    localparam logic [31:0] STEP_GAIN = 32'd8192;
    localparam logic [31:0] ACC_TOP   = 32'h00FF_FFFF;

    cfg_t         cfg;
    logic [1:0]   last_pins;
    logic [7:0]   position;
    logic [23:0]  accel;
    logic         btn_down;
    logic         btn_down_last;
    logic [31:0]  press_t0;
    logic [15:0]  press_len;
    tick_result_t tick_results_due[$];

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        int           d;
        logic [7:0]   old_pos;
        logic [7:0]   diff;
        logic [31:0]  mag;
        logic [39:0]  decayed;
        logic [31:0]  sum;
        logic [5:0]   steps;
        logic         released;
        tick_result_t want;

        if (!rst_n)
        begin
            cfg.reverse_direction = 1'b0;
            cfg.short_press_ms    = SHORT_MS_RESET;
            last_pins     = PINS_IDLE;
            position      = POS_RESET;
            accel         = '0;
            btn_down      = 1'b0;
            btn_down_last = 1'b0;
            press_t0      = '0;
            press_len     = '0;
            tick_results_due.delete();
            mismatches    = 0;
            pending       = 0;
        end
        else
        begin
            // register writes on the access cycle
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_REVERSE:  cfg.reverse_direction = pwdata[0];
                    REG_SHORT_MS: cfg.short_press_ms    = pwdata[15:0];
                    default: ;
                endcase
            end

            // result beats against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (tick_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat expected none, got steps 0x%0h accel 0x%0h",
                             $time, detent_steps, accel_level);
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    compare_field("detent_steps", {26'd0, want.detent_steps},
                                  {26'd0, detent_steps});
                    compare_field("accel_level", {8'd0, want.accel_level}, {8'd0, accel_level});
                    compare_field("pressed", {31'd0, want.btn.pressed}, {31'd0, pressed});
                    compare_field("press_duration_ms", {16'd0, want.btn.press_duration_ms},
                                  {16'd0, press_duration_ms});
                    compare_field("short_release", {31'd0, want.btn.short_release},
                                  {31'd0, short_release});
                    compare_field("activity", {31'd0, want.btn.activity}, {31'd0, activity});
                end
            end

            // input beats update the mirrored state
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_SAMPLE)
                begin
                    // step from {new pins, old pins}
                    case ({pins, last_pins})
                        4'd1, 4'd7, 4'd8, 4'd14:  d = -1;
                        4'd2, 4'd4, 4'd11, 4'd13: d = 1;
                        default:                  d = 0;
                    endcase
                    if (cfg.reverse_direction)
                        d = -d;
                    old_pos = position;
                    if (pins == PINS_IDLE)
                        position = {position[7:2], DETENT_PHASE};
                    else
                        position = position + 8'(d);

                    // |delta| taken as a signed 8-bit difference
                    diff = position - old_pos;
                    mag  = diff[7] ? 32'(9'd256 - {1'b0, diff}) : {24'd0, diff};

                    decayed = {16'd0, accel} * DECAY;
                    sum     = {8'd0, decayed[39:16]} + mag * STEP_GAIN;
                    accel   = (sum > ACC_TOP) ? ACC_TOP[23:0] : sum[23:0];

                    btn_down  = !button_level;
                    last_pins = pins;
                end
                else
                begin
                    // whole detents out, phase bits stay
                    steps    = position[7:2];
                    position = {6'd0, position[1:0]};

                    if (btn_down && !btn_down_last)
                        press_t0 = time_ms;
                    if (btn_down)
                        press_len = 16'(time_ms - press_t0);
                    released = !btn_down && btn_down_last;

                    want.detent_steps          = steps;
                    want.accel_level           = accel;
                    want.btn.pressed           = btn_down;
                    want.btn.press_duration_ms = press_len;
                    want.btn.short_release     = released && steps == 6'd0 &&
                                                 press_len <= cfg.short_press_ms;
                    want.btn.activity          = steps != 6'd0 || btn_down || btn_down_last;
                    tick_results_due.push_back(want);

                    if (released)
                        press_len = '0;
                    btn_down_last = btn_down;
                end
            end
            pending = tick_results_due.size();
        end
    end

endmodule

// File: bench/tb_quadrature_encoder_detent_press_core.sv
// Bench top for the rotary encoder core: clock, reset, register writes, pin/tick stimulus
// and output back-pressure; verdict from the tick checker's mismatch and pending counts.
// Depends on qedp_pkg, qedp_bench_pkg, qedp_tick_checker and the core RTL.
`timescale 1ns / 1ps

module tb_quadrature_encoder_detent_press_core;
    import qedp_pkg::*;
    import qedp_bench_pkg::*;

    localparam int QUIET_LIMIT = 2000;  // cycles without any beat or write
    localparam int HOLD_CYCLES = 120;   // long output hold-off
    localparam int SETTLE      = 4;     // core latency plus margin

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_EVERY3} rx_mode_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              kind         = KIND_SAMPLE;
    logic [1:0]        pins         = PINS_IDLE;
    logic              button_level = 1'b1;
    logic [31:0]       time_ms      = '0;
    logic              out_stall    = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;

    logic              in_stall;
    logic              out_valid;
    logic signed [5:0] detent_steps;
    logic [23:0]       accel_level;
    logic              pressed;
    logic [15:0]       press_duration_ms;
    logic              short_release;
    logic              activity;
    logic [31:0]       prdata;
    logic              pready;

    int mismatches;
    int pending;

    // sender state
    logic [1:0]  cur_pins   = PINS_IDLE;
    logic        btn_lvl    = 1'b1;
    logic [31:0] now        = '0;
    int          burst_left = 0;
    int          items_sent = 0;
    bit          no_gaps    = 1'b0;

    // receiver state
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       hold_left   = 0;
    int       rx_left     = 0;
    int       rx_phase    = 0;
    rx_mode_t rx_mode     = RX_FREE;

    int quiet = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    quadrature_encoder_detent_press_core dut (.*);

    qedp_tick_checker tick_chk (.*);

    // one input beat, with burst/gap pacing in front of it
    task automatic send_beat(input logic k, input logic [1:0] p, input logic b,
                             input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 16);
            if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        kind         <= k;
        pins         <= p;
        button_level <= b;
        time_ms      <= t;
        do @(posedge clk); while (in_stall);
        burst_left--;
        items_sent++;
        if (k == KIND_SAMPLE)
        begin
            cur_pins = p;
            btn_lvl  = b;
        end
    endtask

    // one gray-code step of the knob
    task automatic turn(input bit fwd);
        logic [1:0] nxt;
        if (fwd)
            case (cur_pins)
                2'b11:   nxt = 2'b10;
                2'b10:   nxt = 2'b00;
                2'b00:   nxt = 2'b01;
                default: nxt = 2'b11;
            endcase
        else
            case (cur_pins)
                2'b11:   nxt = 2'b01;
                2'b01:   nxt = 2'b00;
                2'b00:   nxt = 2'b10;
                default: nxt = 2'b11;
            endcase
        send_beat(KIND_SAMPLE, nxt, btn_lvl, $urandom);
    endtask

    // whole detents with the odd contact bounce
    task automatic rotate(input bit fwd, input int detents);
        for (int i = 0; i < 4 * detents; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                turn(!fwd);
                turn(fwd);
            end
            turn(fwd);
        end
    endtask

    task automatic send_tick(input logic [31:0] t);
        now = t;
        send_beat(KIND_TICK, 2'($urandom), 1'($urandom), t);
    endtask

    // time between ticks: mostly short, sometimes long enough to wrap the press length
    function automatic logic [31:0] tick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(60000, 140000);
        else if (r < 6)
            return $urandom_range(0, 30);
        else
            return $urandom_range(30, 300);
    endfunction

    task automatic write_reg(input logic r, input logic [15:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, wait for every tick result, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // receiver back-pressure: random modes, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_asked)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
                RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:  out_stall <= (rx_phase % 3 == 0);
            endcase
        end
    end

    // watchdog: no beat and no register access for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb_quadrature_encoder_detent_press_core failed");
            $finish;
        end
    end

    initial
    begin
        int          target;
        int          pick;
        logic        rev;
        logic [15:0] short_ms;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, one detent each way, glitches, timed presses
        send_tick(32'd0);
        rotate(1'b1, 1);
        send_tick(32'd5);
        rotate(1'b0, 1);
        send_beat(KIND_SAMPLE, 2'b00, 1'b1, 32'hFFFF_FFFF);  // both pins flip at once
        send_beat(KIND_SAMPLE, 2'b11, 1'b1, 32'd0);
        send_beat(KIND_SAMPLE, 2'b10, 1'b1, 32'd0);          // half step, snapped back
        send_beat(KIND_SAMPLE, 2'b11, 1'b1, 32'd0);
        send_tick(32'd9);

        // press of exactly the short limit, across the 32-bit time wrap
        send_beat(KIND_SAMPLE, 2'b11, 1'b0, 32'd0);
        send_tick(32'hFFFF_FF80);
        send_tick(32'h0000_007A);
        send_beat(KIND_SAMPLE, 2'b11, 1'b1, 32'd0);
        send_tick(32'hFFFF_FFFF);

        // release together with a detent turned
        send_beat(KIND_SAMPLE, 2'b11, 1'b0, 32'd0);
        send_tick(32'd100);
        send_beat(KIND_SAMPLE, 2'b10, 1'b1, 32'd0);
        send_beat(KIND_SAMPLE, 2'b00, 1'b1, 32'd0);
        send_tick(32'd200);

        // random phases, each under its own configuration
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:       begin rev = 1'b1; short_ms = 16'd0;     end
                1:       begin rev = 1'b0; short_ms = 16'hFFFF;  end
                2:       begin rev = 1'b1; short_ms = 16'($urandom_range(50, 400)); end
                3:       begin rev = 1'b0; short_ms = SHORT_MS_RESET; end
                4:       begin rev = 1'($urandom); short_ms = 16'($urandom); end
                default: begin rev = 1'b0; short_ms = 16'($urandom_range(100, 300)); end
            endcase
            write_reg(REG_REVERSE, {15'd0, rev});
            write_reg(REG_SHORT_MS, short_ms);
            now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000)
                                              : $urandom;

            // fill the core while the receiver holds off
            if (ph == 2)
            begin
                hold_asked++;
                no_gaps = 1'b1;
                repeat (20)
                begin
                    send_tick(now + tick_gap());
                    turn($urandom_range(0, 1));
                end
                no_gaps = 1'b0;
            end

            target = items_sent + 200;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // turns: mostly a few detents, now and then near the step range limits
                    rotate($urandom_range(0, 1), ($urandom_range(0, 11) == 0)
                           ? $urandom_range(28, 36) : $urandom_range(0, 3));
                    repeat ($urandom_range(0, 3)) turn($urandom_range(0, 1));
                    send_tick(now + tick_gap());
                end
                else if (pick < 65)
                begin
                    // button edge followed by timed ticks
                    send_beat(KIND_SAMPLE, cur_pins, !btn_lvl, $urandom);
                    repeat ($urandom_range(1, 3)) send_tick(now + tick_gap());
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(1, 3)) send_tick(now + tick_gap());
                end
                else
                begin
                    // noise: any fields at all
                    send_beat(1'($urandom), 2'($urandom), 1'($urandom), $urandom);
                end
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("tb_quadrature_encoder_detent_press_core passed");
        else
            $display("tb_quadrature_encoder_detent_press_core failed");
        $finish;
    end

endmodule
